// ===== hdl/order_book_top_of_book_unit_macros.svh =====
// Assertion macros for the top-of-book unit.
`ifndef ORDER_BOOK_TOP_OF_BOOK_UNIT_MACROS_SVH
`define ORDER_BOOK_TOP_OF_BOOK_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define OBTB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("order book assertion failed");

// Next-cycle implication, disabled in reset.
`define OBTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("order book assertion failed");

`endif

// ===== hdl/obtb_pkg.sv =====
// Shared types and constants for the top-of-book unit.
package obtb_pkg;

  // Width of the erase threshold register.
  localparam int THRESH_BITS = 31;

  // Command from the top level to one side's chain.
  typedef struct packed {
    logic capture;  // compare the incoming price against every level
    logic apply;    // commit the item to the chain
    logic erase;    // item removes its price level
  } chain_cmd_t;

  // Control broadcast from a chain to its cells.
  typedef struct packed {
    logic capture;
    logic do_erase;
    logic do_update;
    logic do_insert;
  } cell_ctrl_t;

  // Status of one chain after a capture.
  typedef struct packed {
    logic hit;   // the price is already held
    logic full;  // last cell is in use
  } chain_stat_t;

endpackage

// ===== hdl/obtb_cell.sv =====
// One price level of a sorted side table.
module obtb_cell import obtb_pkg::*; #(
  parameter int PRICE_BITS  = 32,
  parameter int AMOUNT_BITS = 32,
  parameter bit DESC        = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cell_ctrl_t                    ctrl,
  input  logic        [PRICE_BITS-1:0]  cmp_price,
  input  logic        [PRICE_BITS-1:0]  new_price,
  input  logic signed [AMOUNT_BITS-1:0] new_amount,
  input  logic                          prev_boe,
  input  logic                          prev_valid,
  input  logic        [PRICE_BITS-1:0]  prev_price,
  input  logic signed [AMOUNT_BITS-1:0] prev_amount,
  input  logic                          next_valid,
  input  logic        [PRICE_BITS-1:0]  next_price,
  input  logic signed [AMOUNT_BITS-1:0] next_amount,
  output logic                          valid,
  output logic        [PRICE_BITS-1:0]  price,
  output logic signed [AMOUNT_BITS-1:0] amount,
  output logic                          boe,
  output logic                          hit
);

  logic key_first;

  // Incoming price sorts at or ahead of this level
  assign key_first = DESC ? (cmp_price >= price) : (cmp_price <= price);

  // Hold valid bit and compare flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      boe   <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctrl.capture) begin
        boe <= !valid || key_first;
        hit <= valid && (price == cmp_price);
      end
      if (ctrl.do_erase && boe) begin
        valid <= next_valid;
      end else if (ctrl.do_insert && boe) begin
        valid <= prev_boe ? prev_valid : 1'b1;
      end
    end
  end

  // Shift up on erase, shift down or load on insert, overwrite on update
  always_ff @(posedge clk) begin
    if (ctrl.do_erase && boe) begin
      price  <= next_price;
      amount <= next_amount;
    end else if (ctrl.do_insert && boe) begin
      price  <= prev_boe ? prev_price : new_price;
      amount <= prev_boe ? prev_amount : new_amount;
    end else if (ctrl.do_update && hit) begin
      amount <= new_amount;
    end
  end

endmodule

// ===== hdl/obtb_chain.sv =====
// Sorted row of level cells for one book side; best level sits in the first cell.
module obtb_chain import obtb_pkg::*; #(
  parameter int LEVELS      = 64,
  parameter int PRICE_BITS  = 32,
  parameter int AMOUNT_BITS = 32,
  parameter bit DESC        = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  chain_cmd_t                    cmd,
  input  logic        [PRICE_BITS-1:0]  cmp_price,
  input  logic        [PRICE_BITS-1:0]  new_price,
  input  logic signed [AMOUNT_BITS-1:0] new_amount,
  output chain_stat_t                   stat,
  output logic                          head_valid,
  output logic        [PRICE_BITS-1:0]  head_price,
  output logic signed [AMOUNT_BITS-1:0] head_amount
);

  // Entry 0 and entry LEVELS+1 are empty ends of the row
  logic                          valid_ext  [LEVELS+2];
  logic        [PRICE_BITS-1:0]  price_ext  [LEVELS+2];
  logic signed [AMOUNT_BITS-1:0] amount_ext [LEVELS+2];
  logic                          boe_ext    [LEVELS+1];
  logic        [LEVELS-1:0]      hit_vec;
  cell_ctrl_t                    ctrl;

  assign valid_ext[0]         = 1'b0;
  assign price_ext[0]         = '0;
  assign amount_ext[0]        = '0;
  assign boe_ext[0]           = 1'b0;
  assign valid_ext[LEVELS+1]  = 1'b0;
  assign price_ext[LEVELS+1]  = '0;
  assign amount_ext[LEVELS+1] = '0;

  // Summarize the captured compare flags
  assign stat.hit  = |hit_vec;
  assign stat.full = valid_ext[LEVELS];

  // Pick the operation the cells carry out
  always_comb begin
    ctrl.capture   = cmd.capture;
    ctrl.do_erase  = cmd.apply && cmd.erase && stat.hit;
    ctrl.do_update = cmd.apply && !cmd.erase && stat.hit;
    ctrl.do_insert = cmd.apply && !cmd.erase && !stat.hit && !stat.full;
  end

  // Row of cells, each linked to both neighbors
  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    obtb_cell #(
      .PRICE_BITS (PRICE_BITS),
      .AMOUNT_BITS(AMOUNT_BITS),
      .DESC       (DESC)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .cmp_price  (cmp_price),
      .new_price  (new_price),
      .new_amount (new_amount),
      .prev_boe   (boe_ext[g]),
      .prev_valid (valid_ext[g]),
      .prev_price (price_ext[g]),
      .prev_amount(amount_ext[g]),
      .next_valid (valid_ext[g+2]),
      .next_price (price_ext[g+2]),
      .next_amount(amount_ext[g+2]),
      .valid      (valid_ext[g+1]),
      .price      (price_ext[g+1]),
      .amount     (amount_ext[g+1]),
      .boe        (boe_ext[g+1]),
      .hit        (hit_vec[g])
    );
  end

  assign head_valid  = valid_ext[1];
  assign head_price  = price_ext[1];
  assign head_amount = amount_ext[1];

endmodule

// ===== hdl/order_book_top_of_book_unit.sv =====
// Top level of the top-of-book unit: item handshake, side chains, result register.
//
// Input channel (in_valid/in_ready) carries one update item: side, price, amount.
// An amount whose magnitude is below erase_threshold removes that price level,
// any other amount inserts the level or overwrites its amount.
// Output channel (out_valid/out_ready) carries one result per item: best ask,
// best bid (each with a valid flag, zero fields when empty) and a dropped flag
// set when a new level found its side full.
// Each side is a sorted row of LEVELS cells. On acceptance every cell of the
// item's side compares the item price with its own; the next cycle the row
// shifts or updates in place; then, once the result register is free, the heads
// of both rows are loaded into it. The rows compare and commit one item at a
// time; a new item is taken in the cycle its predecessor's result is loaded.
// If the receiver stalls, the result is held; one further result can wait in the
// row heads, after which in_ready stays low until out_ready returns.
// Synchronous reset empties both sides, drops any pending result and sets
// erase_threshold to 1. Write erase_threshold only while the unit is idle.
module order_book_top_of_book_unit import obtb_pkg::*; #(
  parameter int LEVELS      = 64,
  parameter int PRICE_BITS  = 32,
  parameter int AMOUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic        [THRESH_BITS-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          side,
  input  logic        [PRICE_BITS-1:0]  price,
  input  logic signed [AMOUNT_BITS-1:0] amount,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ask_valid,
  output logic        [PRICE_BITS-1:0]  ask_price,
  output logic signed [AMOUNT_BITS-1:0] ask_amount,
  output logic                          bid_valid,
  output logic        [PRICE_BITS-1:0]  bid_price,
  output logic signed [AMOUNT_BITS-1:0] bid_amount,
  output logic                          dropped
);

  `include "order_book_top_of_book_unit_macros.svh"

  localparam int CMP_BITS = (AMOUNT_BITS > THRESH_BITS) ? AMOUNT_BITS : THRESH_BITS;

  typedef enum logic [1:0] {S_IDLE, S_APPLY, S_REPORT} state_t;

  state_t                        state;
  logic        [THRESH_BITS-1:0] erase_threshold;
  logic                          item_side;
  logic        [PRICE_BITS-1:0]  item_price;
  logic signed [AMOUNT_BITS-1:0] item_amount;
  logic                          item_erase;
  logic                          drop_pend;
  logic        [AMOUNT_BITS-1:0] amount_mag;
  logic                          erase_now;
  logic                          accept;
  logic                          out_load;
  chain_cmd_t                    ask_cmd;
  chain_cmd_t                    bid_cmd;
  chain_stat_t                   ask_stat;
  chain_stat_t                   bid_stat;
  chain_stat_t                   sel_stat;
  logic                          ask_head_valid;
  logic        [PRICE_BITS-1:0]  ask_head_price;
  logic signed [AMOUNT_BITS-1:0] ask_head_amount;
  logic                          bid_head_valid;
  logic        [PRICE_BITS-1:0]  bid_head_price;
  logic signed [AMOUNT_BITS-1:0] bid_head_amount;

  // Handshake: take an item when idle or when the previous result leaves
  assign out_load = (state == S_REPORT) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE) || out_load;
  assign accept   = in_valid && in_ready;

  // Magnitude of the amount; the most negative value maps to 2^(AMOUNT_BITS-1)
  assign amount_mag = amount[AMOUNT_BITS-1] ? ((~amount) + AMOUNT_BITS'(1)) : amount;
  assign erase_now  = CMP_BITS'(amount_mag) < CMP_BITS'(erase_threshold);

  // Commands for the two side chains
  always_comb begin
    ask_cmd.capture = accept && !side;
    ask_cmd.apply   = (state == S_APPLY) && !item_side;
    ask_cmd.erase   = item_erase;
    bid_cmd.capture = accept && side;
    bid_cmd.apply   = (state == S_APPLY) && item_side;
    bid_cmd.erase   = item_erase;
  end

  assign sel_stat = item_side ? bid_stat : ask_stat;

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      erase_threshold <= THRESH_BITS'(1);
    end else begin
      if (cfg_we) begin
        erase_threshold <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= S_REPORT;
        end
        S_REPORT: begin
          if (out_load) begin
            state <= accept ? S_APPLY : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the item, the drop flag and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_side   <= side;
      item_price  <= price;
      item_amount <= amount;
      item_erase  <= erase_now;
    end
    if (state == S_APPLY) begin
      drop_pend <= !item_erase && !sel_stat.hit && sel_stat.full;
    end
    if (out_load) begin
      ask_valid  <= ask_head_valid;
      ask_price  <= ask_head_valid ? ask_head_price : '0;
      ask_amount <= ask_head_valid ? ask_head_amount : '0;
      bid_valid  <= bid_head_valid;
      bid_price  <= bid_head_valid ? bid_head_price : '0;
      bid_amount <= bid_head_valid ? bid_head_amount : '0;
      dropped    <= drop_pend;
    end
  end

  // Ask side: ascending, lowest price first
  obtb_chain #(
    .LEVELS     (LEVELS),
    .PRICE_BITS (PRICE_BITS),
    .AMOUNT_BITS(AMOUNT_BITS),
    .DESC       (1'b0)
  ) u_ask (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ask_cmd),
    .cmp_price  (price),
    .new_price  (item_price),
    .new_amount (item_amount),
    .stat       (ask_stat),
    .head_valid (ask_head_valid),
    .head_price (ask_head_price),
    .head_amount(ask_head_amount)
  );

  // Bid side: descending, highest price first
  obtb_chain #(
    .LEVELS     (LEVELS),
    .PRICE_BITS (PRICE_BITS),
    .AMOUNT_BITS(AMOUNT_BITS),
    .DESC       (1'b1)
  ) u_bid (
    .clk        (clk),
    .rst        (rst),
    .cmd        (bid_cmd),
    .cmp_price  (price),
    .new_price  (item_price),
    .new_amount (item_amount),
    .stat       (bid_stat),
    .head_valid (bid_head_valid),
    .head_price (bid_head_price),
    .head_amount(bid_head_amount)
  );

  // An accepted item is committed in the following cycle
  `OBTB_ASSERT_NEXT(a_accept_commits, clk, rst, accept, state == S_APPLY)
  // A commit is always followed by a report
  `OBTB_ASSERT_NEXT(a_commit_reports, clk, rst, state == S_APPLY, state == S_REPORT)
  // No item is taken while the rows are being committed
  `OBTB_ASSERT_NOW(a_no_take_in_commit, clk, rst, state == S_APPLY, !in_ready)
  // Loading a result always presents it
  `OBTB_ASSERT_NEXT(a_load_presents, clk, rst, out_load, out_valid)

endmodule

// ===== bench/tb_order_book_top_of_book_unit.sv =====
// Self-checking testbench for the order book top-of-book unit.
`timescale 1ns / 100ps

module tb_order_book_top_of_book_unit import obtb_pkg::*;;

  localparam int LEVELS      = 64;
  localparam int PRICE_BITS  = 32;
  localparam int AMOUNT_BITS = 32;

  localparam bit SIDE_ASK = 1'b0;
  localparam bit SIDE_BID = 1'b1;

  localparam logic signed [AMOUNT_BITS-1:0] AMOUNT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [AMOUNT_BITS-1:0] AMOUNT_MIN = 32'sh8000_0000;
  localparam logic [THRESH_BITS-1:0] THRESH_MAX = '1;
  localparam int LONG_HOLD_CYCLES = 80;

  typedef struct {
    logic                          side;
    logic        [PRICE_BITS-1:0]  price;
    logic signed [AMOUNT_BITS-1:0] amount;
  } book_update_t;

  typedef struct {
    logic                          ask_valid;
    logic        [PRICE_BITS-1:0]  ask_price;
    logic signed [AMOUNT_BITS-1:0] ask_amount;
    logic                          bid_valid;
    logic        [PRICE_BITS-1:0]  bid_price;
    logic signed [AMOUNT_BITS-1:0] bid_amount;
    logic                          dropped;
  } top_quote_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_we    = 1'b0;
  logic        [THRESH_BITS-1:0] cfg_wdata = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic                          side      = 1'b0;
  logic        [PRICE_BITS-1:0]  price     = '0;
  logic signed [AMOUNT_BITS-1:0] amount    = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          ask_valid;
  logic        [PRICE_BITS-1:0]  ask_price;
  logic signed [AMOUNT_BITS-1:0] ask_amount;
  logic                          bid_valid;
  logic        [PRICE_BITS-1:0]  bid_price;
  logic signed [AMOUNT_BITS-1:0] bid_amount;
  logic                          dropped;

  // Book model: one row of levels per side, indexed by side code
  logic        [PRICE_BITS-1:0]  level_price  [2][LEVELS];
  logic signed [AMOUNT_BITS-1:0] level_amount [2][LEVELS];
  bit                            level_used   [2][LEVELS];
  logic        [THRESH_BITS-1:0] erase_level = THRESH_BITS'(1);

  book_update_t update_queue[$];
  top_quote_t   expected_quotes[$];

  int error_count    = 0;
  int send_gap       = 0;
  int hold_cnt       = 0;
  bit steady_mode    = 1'b0;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;

  order_book_top_of_book_unit #(
    .LEVELS      (LEVELS),
    .PRICE_BITS  (PRICE_BITS),
    .AMOUNT_BITS (AMOUNT_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .side       (side),
    .price      (price),
    .amount     (amount),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ask_valid  (ask_valid),
    .ask_price  (ask_price),
    .ask_amount (ask_amount),
    .bid_valid  (bid_valid),
    .bid_price  (bid_price),
    .bid_amount (bid_amount),
    .dropped    (dropped)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Find the best level of one side: lowest ask, highest bid
  function automatic void best_level(input bit sd, output logic vld,
                                     output logic [PRICE_BITS-1:0] px,
                                     output logic signed [AMOUNT_BITS-1:0] amt);
    int best;
    best = -1;
    for (int i = 0; i < LEVELS; i++) begin
      if (level_used[sd][i] && (best < 0 ||
          (sd == SIDE_BID ? level_price[sd][i] > level_price[sd][best]
                          : level_price[sd][i] < level_price[sd][best])))
        best = i;
    end
    vld = 1'b0;
    px  = '0;
    amt = '0;
    if (best >= 0) begin
      vld = 1'b1;
      px  = level_price[sd][best];
      amt = level_amount[sd][best];
    end
  endfunction

  // Apply one update to the book model and return the quote it yields
  function automatic top_quote_t apply_update(input book_update_t u);
    top_quote_t            q;
    logic [AMOUNT_BITS:0]  mag;
    int                    hit;
    int                    slot;
    hit  = -1;
    slot = -1;
    mag  = u.amount[AMOUNT_BITS-1] ? -{1'b1, u.amount} : {1'b0, u.amount};
    for (int i = 0; i < LEVELS; i++) begin
      if (level_used[u.side][i] && level_price[u.side][i] == u.price && hit < 0)
        hit = i;
      if (!level_used[u.side][i] && slot < 0)
        slot = i;
    end
    q.dropped = 1'b0;
    if (mag < {2'b00, erase_level}) begin
      if (hit >= 0)
        level_used[u.side][hit] = 1'b0;
    end else if (hit >= 0) begin
      level_amount[u.side][hit] = u.amount;
    end else if (slot >= 0) begin
      level_used[u.side][slot]   = 1'b1;
      level_price[u.side][slot]  = u.price;
      level_amount[u.side][slot] = u.amount;
    end else begin
      q.dropped = 1'b1;
    end
    best_level(SIDE_ASK, q.ask_valid, q.ask_price, q.ask_amount);
    best_level(SIDE_BID, q.bid_valid, q.bid_price, q.bid_amount);
    return q;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_mode || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] exp_v,
                                      input logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  function automatic void queue_update(input bit sd, input logic [PRICE_BITS-1:0] px,
                                       input logic signed [AMOUNT_BITS-1:0] amt);
    update_queue.push_back(book_update_t'{sd, px, amt});
  endfunction

  // Remove every level the model holds on one side (threshold must be nonzero)
  function automatic void queue_side_clear(input bit sd);
    for (int i = 0; i < LEVELS; i++)
      if (level_used[sd][i])
        queue_update(sd, level_price[sd][i], '0);
  endfunction

  // Random updates: mostly prices from a small pool so levels get hit and sides fill
  function automatic void queue_random_updates(input int count);
    logic        [PRICE_BITS-1:0]  base;
    logic        [PRICE_BITS-1:0]  px;
    logic signed [AMOUNT_BITS-1:0] amt;
    logic        [AMOUNT_BITS-1:0] mag;
    int                            r;
    base = $urandom;
    repeat (count) begin
      px = ($urandom_range(0, 99) < 75) ? base + $urandom_range(0, 79) : $urandom;
      r = $urandom_range(0, 99);
      if (r < 25) begin
        mag = (erase_level == 0) ? '0 : $urandom_range(0, erase_level - 1);
        amt = $urandom_range(0, 1) ? -mag : mag;
      end else if (r < 32) begin
        case ($urandom_range(0, 3))
          0: amt = AMOUNT_MAX;
          1: amt = AMOUNT_MIN;
          2: amt = {1'b0, erase_level};
          default: amt = -{1'b0, erase_level};
        endcase
      end else begin
        amt = $urandom;
      end
      queue_update(1'($urandom_range(0, 1)), px, amt);
    end
  endfunction

  // Wait until every item has been sent and every quote has come back
  task automatic wait_for_drain();
    do @(negedge clk);
    while (update_queue.size() > 0 || in_valid || expected_quotes.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [THRESH_BITS-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    erase_level = v;
    @(negedge clk);
  endtask

  // Drive update items; predict the quote of each accepted item
  always @(posedge clk) begin : drive_updates
    book_update_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_quotes.push_back(apply_update(book_update_t'{side, price, amount}));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (update_queue.size() > 0) begin
          nxt = update_queue.pop_front();
          side     <= nxt.side;
          price    <= nxt.price;
          amount   <= nxt.amount;
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Accept quotes, compare with the oldest prediction, and stall at random
  always @(posedge clk) begin : check_quotes
    top_quote_t exp_q;
    int         g;
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_quotes.size() == 0) begin
          $error("quote received with no update item waiting");
          error_count++;
        end else begin
          exp_q = expected_quotes.pop_front();
          check_field("ask_valid", 64'(exp_q.ask_valid), 64'(ask_valid));
          check_field("ask_price", 64'(exp_q.ask_price), 64'(ask_price));
          check_field("ask_amount", 64'(exp_q.ask_amount), 64'(ask_amount));
          check_field("bid_valid", 64'(exp_q.bid_valid), 64'(bid_valid));
          check_field("bid_price", 64'(exp_q.bid_price), 64'(bid_price));
          check_field("bid_amount", 64'(exp_q.bid_amount), 64'(bid_amount));
          check_field("dropped", 64'(exp_q.dropped), 64'(dropped));
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
        // Hold off long enough for the unit to back up and drop in_ready
        long_hold_done <= 1'b1;
        hold_cnt       <= LONG_HOLD_CYCLES;
        out_ready      <= 1'b0;
      end else begin
        g = pick_gap();
        out_ready <= (g == 0);
        hold_cnt  <= (g > 0) ? g - 1 : 0;
      end
    end
  end

  initial begin : run_phases
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Insert, overwrite and remove at the extremes, with the reset threshold
    queue_update(SIDE_ASK, 32'd100, 32'sd50);
    queue_update(SIDE_BID, 32'd90, 32'sd40);
    queue_update(SIDE_ASK, 32'd0, AMOUNT_MAX);
    queue_update(SIDE_BID, 32'hFFFF_FFFF, AMOUNT_MIN);
    queue_update(SIDE_ASK, 32'd100, -32'sd3);
    queue_update(SIDE_ASK, 32'd0, 32'sd0);
    queue_update(SIDE_ASK, 32'd555, 32'sd0);
    queue_update(SIDE_BID, 32'hFFFF_FFFF, 32'sd1);
    queue_update(SIDE_BID, 32'hFFFF_FFFF, -32'sd1);
    queue_update(SIDE_BID, 32'hFFFF_FFFF, 32'sd0);
    queue_update(SIDE_BID, 32'd90, 32'sd0);
    queue_update(SIDE_ASK, 32'd100, 32'sd0);

    // Fill the bid side, then a new level is dropped while an overwrite is not
    for (int i = 0; i < LEVELS; i++)
      queue_update(SIDE_BID, 32'd1000 + 3 * i, i + 1);
    queue_update(SIDE_BID, 32'd5000, 32'sd9);
    queue_update(SIDE_BID, 32'd1000, 32'sd77);
    queue_update(SIDE_BID, 32'd1, -32'sd9);
    queue_update(SIDE_BID, 32'd2000, 32'sd0);
    wait_for_drain();
    queue_side_clear(SIDE_BID);
    wait_for_drain();

    // Threshold zero: zero amounts are stored, nothing is removed
    write_threshold('0);
    queue_update(SIDE_ASK, 32'd42, 32'sd0);
    queue_update(SIDE_ASK, 32'd42, 32'sd0);
    queue_update(SIDE_BID, 32'd7, 32'sd0);
    queue_update(SIDE_ASK, 32'd42, -32'sd3);
    wait_for_drain();

    // Largest threshold: only the two extreme magnitudes survive
    write_threshold(THRESH_MAX);
    queue_update(SIDE_ASK, 32'd42, AMOUNT_MAX);
    queue_update(SIDE_ASK, 32'd42, 32'sh7FFF_FFFE);
    queue_update(SIDE_BID, 32'd7, AMOUNT_MIN);
    queue_update(SIDE_BID, 32'd7, 32'sd1);
    queue_update(SIDE_ASK, 32'd9, AMOUNT_MIN);
    queue_update(SIDE_ASK, 32'd9, -AMOUNT_MAX);
    wait_for_drain();

    // Random phases under several thresholds
    write_threshold(THRESH_BITS'($urandom_range(2, 1000)));
    queue_random_updates(90);
    long_hold_req = 1'b1;
    wait_for_drain();

    write_threshold('0);
    steady_mode = 1'b1;
    queue_random_updates(90);
    wait_for_drain();
    steady_mode = 1'b0;

    write_threshold(THRESH_BITS'(1));
    queue_random_updates(90);
    wait_for_drain();
    queue_side_clear(SIDE_ASK);
    queue_side_clear(SIDE_BID);
    wait_for_drain();

    write_threshold(THRESH_BITS'($urandom & THRESH_MAX));
    queue_random_updates(90);
    wait_for_drain();

    write_threshold(THRESH_BITS'(50));
    queue_random_updates(90);
    wait_for_drain();

    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal schedule
  initial begin : run_limit
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
